### src/fra_pkg.sv
// fra_pkg: shared constants, types and codes for the frame rate averager
// no dependencies; imported by every module of the block but fra_ram
`timescale 1ns / 1ps

package fra_pkg;

  // ring geometry
  localparam int RING_DEPTH = 16;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // field widths
  localparam int ACT_W = 2;
  localparam int TS_W  = 32;
  localparam int FPS_W = 28;

  // running sum never wraps: depth times the largest duration
  localparam int SUM_W = TS_W + SLOT_W;

  // dividend is scale times count
  localparam int NUM_W  = FPS_W + CNT_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  // 256000000 = 1000000 us per second with 8 fraction bits
  localparam logic [FPS_W-1:0] FPS_SCALE_Q8 = FPS_W'(256000000);

  // action codes
  localparam logic [ACT_W-1:0] ACT_START = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  // controller states
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_MUL    = 5'b00100,
    S_DIV    = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;    // latch the event, start the ring read
    logic update;    // apply the event to the stored state
    logic mul;       // form the dividend, clear the remainder
    logic div_step;  // one restoring division step
    logic load_out;  // move the result into the output register
  } cmd_t;

endpackage

### src/fra_ram.sv
// fra_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module fra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/fra_ctrl.sv
// fra_ctrl: sequencing state machine for one event at a time
// depends on fra_pkg
`timescale 1ns / 1ps

module fra_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  output logic          busy,
  output fra_pkg::cmd_t cmd
);

  import fra_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NUM_W - 1)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### src/fra_dp.sv
// fra_dp: ring store, running sum and count, bit-serial divider, output register
// depends on fra_pkg and fra_ram
`timescale 1ns / 1ps

module fra_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  fra_pkg::cmd_t             cmd,
  input  logic [fra_pkg::ACT_W-1:0] in_action,
  input  logic [fra_pkg::TS_W-1:0]  in_timestamp_us,
  input  logic                      out_stall,
  output logic                      out_free,
  output logic                      out_valid,
  output logic [fra_pkg::FPS_W-1:0] out_fps_q8,
  output logic                      out_has_data,
  output logic                      out_sample_stored
);

  import fra_pkg::*;

  // latched event
  logic [ACT_W-1:0] act_r;
  logic [TS_W-1:0]  ts_r;

  // frame and ring state
  logic [TS_W-1:0]       start_r, start_nxt;
  logic                  open_r, open_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [RING_DEPTH-1:0] vld_r, vld_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  stored_r, stored_nxt;

  // divider
  logic [SUM_W-1:0] rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [SUM_W:0]   trial;

  // output register
  logic             ovld_r;
  logic [FPS_W-1:0] ofps_r;
  logic             ohas_r;
  logic             ostored_r;

  logic [TS_W-1:0] rdata;
  logic [TS_W-1:0] old_dur;
  logic [TS_W-1:0] new_dur;
  logic            ram_we;

  fra_ram #(
    .WIDTH (TS_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (new_dur),
    .re    (cmd.accept),
    .raddr (slot_r),
    .rdata (rdata)
  );

  // entries not written since clear read as empty
  assign old_dur = vld_r[slot_r] ? rdata : '0;
  assign new_dur = ts_r - start_r;
  assign ram_we  = cmd.update && (act_r == ACT_END) && open_r;

  always_comb begin
    start_nxt  = start_r;
    open_nxt   = open_r;
    slot_nxt   = slot_r;
    vld_nxt    = vld_r;
    sum_nxt    = sum_r;
    cnt_nxt    = cnt_r;
    stored_nxt = stored_r;
    if (cmd.update) begin
      stored_nxt = 1'b0;
      case (act_r)
        ACT_START: begin
          start_nxt = ts_r;
          open_nxt  = 1'b1;
        end
        ACT_END: begin
          if (open_r) begin
            sum_nxt = sum_r - SUM_W'(old_dur) + SUM_W'(new_dur);
            cnt_nxt = cnt_r - CNT_W'(old_dur != '0) + CNT_W'(new_dur != '0);
            vld_nxt[slot_r] = 1'b1;
            slot_nxt   = (slot_r == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
            open_nxt   = 1'b0;
            stored_nxt = 1'b1;
          end
        end
        ACT_CLEAR: begin
          start_nxt = '0;
          open_nxt  = 1'b0;
          slot_nxt  = '0;
          vld_nxt   = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      open_r  <= 1'b0;
      slot_r  <= '0;
      vld_r   <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
    end else begin
      start_r <= start_nxt;
      open_r  <= open_nxt;
      slot_r  <= slot_nxt;
      vld_r   <= vld_nxt;
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stored_r <= stored_nxt;
    if (cmd.accept) begin
      act_r <= in_action;
      ts_r  <= in_timestamp_us;
    end
  end

  // restoring division: quotient bits shift in as dividend bits shift out
  assign trial = {rem_r, quo_r[NUM_W-1]} - {1'b0, sum_r};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r <= NUM_W'(FPS_SCALE_Q8) * NUM_W'(cnt_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial[SUM_W]) begin
        rem_r <= trial[SUM_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[SUM_W-2:0], quo_r[NUM_W-1]};
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign out_free = !ovld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.load_out) begin
      ovld_r <= 1'b1;
    end else if (!out_stall) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ofps_r    <= (cnt_r != '0) ? quo_r[FPS_W-1:0] : '0;
      ohas_r    <= (cnt_r != '0);
      ostored_r <= stored_r;
    end
  end

  assign out_valid         = ovld_r;
  assign out_fps_q8        = ofps_r;
  assign out_has_data      = ohas_r;
  assign out_sample_stored = ostored_r;

endmodule

### src/frame_rate_averager.sv
// frame_rate_averager: top level, ties the controller to the datapath
// depends on fra_pkg, fra_ctrl, fra_dp (and through it fra_ram)
`timescale 1ns / 1ps

// frame rate meter over the last RING_DEPTH (16) frame durations. each input
// transfer is an event: start frame records the timestamp, end frame stores
// the elapsed microseconds (mod 2^32) into the ring when a frame is open,
// clear empties the ring. every event gives exactly one result transfer with
// the average rate in unsigned q.8 fps (256000000 * count / sum, truncated),
// a has-data flag and whether this event stored a duration. zero durations
// are stored but count as empty. one event is worked on at a time: the
// restoring divider makes one quotient bit a cycle, and a new event is
// taken in the cycle after the result is loaded into the output register,
// even while that result still waits to be taken.
// no clearing pass after reset: the ring has one valid bit per entry.

module frame_rate_averager (
  input  logic                      clk,
  input  logic                      rst_n,
  // event channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [fra_pkg::ACT_W-1:0] in_action,
  input  logic [fra_pkg::TS_W-1:0]  in_timestamp_us,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fra_pkg::FPS_W-1:0] out_fps_q8,
  output logic                      out_has_data,
  output logic                      out_sample_stored
);

  import fra_pkg::*;

  cmd_t cmd;
  logic busy;
  logic out_free;

  // controller: idle, update, multiply, divide loop, output load
  fra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .busy     (busy),
    .cmd      (cmd)
  );

  // datapath: ring ram, running sum and count, divider, output register
  fra_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_action         (in_action),
    .in_timestamp_us   (in_timestamp_us),
    .out_stall         (out_stall),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_fps_q8        (out_fps_q8),
    .out_has_data      (out_has_data),
    .out_sample_stored (out_sample_stored)
  );

  // events are taken only while the controller is idle
  assign in_stall = busy;

endmodule

### src/fra_checker.sv
// fra_checker: port-level assertions for frame_rate_averager, with its bind
// depends on fra_pkg
`timescale 1ns / 1ps

module fra_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [fra_pkg::FPS_W-1:0] out_fps_q8,
  input logic                      out_has_data,
  input logic                      out_sample_stored
);

  import fra_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fps_q8)
      && $stable(out_has_data) && $stable(out_sample_stored))
    else $error("stalled result changed");

  // one event at a time: busy right after a transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("event taken while busy");

  // no rate without data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_fps_q8 == '0)
    else $error("rate without data");

  // rate never above one frame per microsecond
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fps_q8 <= FPS_SCALE_Q8)
    else $error("rate out of range");

  // nothing comes out of reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind frame_rate_averager fra_checker u_fra_checker (.*);

### tb/tb_top.sv
// tb_top: self-checking testbench for the frame rate averager
// holds the event predictor and scoreboard class, the stimulus and the checks
// depends on fra_pkg and frame_rate_averager
`timescale 1ns / 1ps

import fra_pkg::*;

typedef struct packed {
  logic [FPS_W-1:0] fps_q8;
  logic             has_data;
  logic             sample_stored;
} fps_result_t;

// tracks the frame ring on each event transfer and checks each result
class fps_scoreboard;
  logic [TS_W-1:0]  start_ts;
  bit               open;
  logic [TS_W-1:0]  ring [RING_DEPTH];
  int unsigned      slot;
  logic [SUM_W-1:0] sum;
  int unsigned      count;
  fps_result_t      expected_q [$];
  int unsigned      errors;

  function new();
    errors = 0;
    clear_ring();
  endfunction

  function void clear_ring();
    foreach (ring[i]) ring[i] = '0;
    slot     = 0;
    sum      = '0;
    count    = 0;
    start_ts = '0;
    open     = 1'b0;
  endfunction

  function void note_event(logic [ACT_W-1:0] act, logic [TS_W-1:0] ts);
    logic [TS_W-1:0] dur;
    logic [TS_W-1:0] old;
    logic [63:0]     quot;
    fps_result_t     r;
    r = '0;
    case (act)
      ACT_START: begin
        start_ts = ts;
        open     = 1'b1;
      end
      ACT_END: begin
        if (open) begin
          dur = ts - start_ts;
          old = ring[slot];
          if (old != 0) begin
            sum   = sum - SUM_W'(old);
            count = count - 1;
          end
          ring[slot] = dur;
          if (dur != 0) begin
            sum   = sum + SUM_W'(dur);
            count = count + 1;
          end
          slot            = (slot + 1) % RING_DEPTH;
          open            = 1'b0;
          r.sample_stored = 1'b1;
        end
      end
      ACT_CLEAR: clear_ring();
      default: ;
    endcase
    if (count != 0 && sum != 0) begin
      quot     = (64'(FPS_SCALE_Q8) * 64'(count)) / 64'(sum);
      r.fps_q8 = quot[FPS_W-1:0];
    end
    r.has_data = (count != 0);
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [FPS_W-1:0] fps, logic has, logic stored);
    fps_result_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no pending event: fps_q8 %0d", fps);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (fps !== e.fps_q8) begin
      $error("fps_q8: expected %0d, actual %0d", e.fps_q8, fps);
      errors++;
    end
    if (has !== e.has_data) begin
      $error("has_data: expected %0d, actual %0d", e.has_data, has);
      errors++;
    end
    if (stored !== e.sample_stored) begin
      $error("sample_stored: expected %0d, actual %0d", e.sample_stored, stored);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;

  // action code 3 has no meaning, the block must ignore it
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  localparam int RAND_ITEMS     = 1600;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] in_action = '0;
  logic [TS_W-1:0]  in_timestamp_us = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [FPS_W-1:0] out_fps_q8;
  logic             out_has_data;
  logic             out_sample_stored;

  fps_scoreboard sb = new();

  // transfer counters, written only by the monitor
  int unsigned events_in = 0;
  int unsigned results_out = 0;

  // sender side idling switch, changed between stimulus chunks
  bit tx_idle_on = 1'b1;

  // receiver state
  bit          rx_idle_on = 1'b1;
  bit          burst_hold = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_seen = 0;

  int unsigned idle_cycles = 0;

  frame_rate_averager uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_timestamp_us  (in_timestamp_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_fps_q8       (out_fps_q8),
    .out_has_data     (out_has_data),
    .out_sample_stored(out_sample_stored)
  );

  always #5 clk = ~clk;

  // monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_event(in_action, in_timestamp_us);
        events_in++;
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_fps_q8, out_has_data, out_sample_stored);
        results_out++;
      end
    end
  end

  // receiver: draws a wait for every result, and the wait only runs down
  // while a result is offered, so stalls land on valid results as well
  always @(negedge clk) begin
    if (results_out != rx_seen) begin
      rx_seen = results_out;
      // every 150 results, maybe switch idling off for a stretch
      if (rx_seen % 150 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
      rx_wait = rx_idle_on ? $urandom_range(0, 3) : 0;
    end
    out_stall <= burst_hold || (rx_wait != 0);
    if (out_valid && rx_wait != 0) rx_wait--;
  end

  // long hold-off on the result side so the block fills and stalls its input
  initial begin
    wait (events_in >= 300);
    @(posedge clk);
    burst_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    burst_hold = 1'b0;
  end

  // one event transfer, with a random gap ahead of it
  task automatic send_event(input logic [ACT_W-1:0] act, input logic [TS_W-1:0] ts);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_action       <= act;
    in_timestamp_us <= ts;
    // hold the payload until the block takes it
    do @(posedge clk); while (in_stall);
  endtask

  // frame duration drawn from a mix of typical, tiny, zero and huge values
  function automatic logic [TS_W-1:0] pick_duration();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0:       return '0;
      6:       return TS_W'($urandom_range(1, 20));
      7:       return TS_W'($urandom);
      8:       return 32'hFFFF_FFFF - TS_W'($urandom_range(0, 1000));
      9:       return TS_W'($urandom_range(10000, 40000));
      default: return TS_W'($urandom_range(1, 100000));
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned     sent;
    int unsigned     sel;
    logic [TS_W-1:0] t0;
    logic [ACT_W-1:0] act;
    sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // end with no frame open, unused code, clear on an empty ring
    send_event(ACT_END, 32'h1234_5678);
    send_event(ACT_UNUSED, 32'hFFFF_FFFF);
    send_event(ACT_CLEAR, 32'h0);
    // zero duration is stored but stays out of sum and count
    send_event(ACT_START, 32'h0);
    send_event(ACT_END, 32'h0);
    // shortest nonzero frame gives the top rate
    send_event(ACT_START, 32'h0);
    send_event(ACT_END, 32'h1);
    // second end with the frame already closed
    send_event(ACT_END, 32'h5);
    // elapsed time across the timestamp wrap
    send_event(ACT_START, 32'hFFFF_FFF0);
    send_event(ACT_END, 32'h0000_0010);
    // restart replaces the start time
    send_event(ACT_START, 32'd100);
    send_event(ACT_START, 32'd5000);
    send_event(ACT_END, 32'd5100);
    // longest frame
    send_event(ACT_START, 32'h0);
    send_event(ACT_END, 32'hFFFF_FFFF);
    // unused code inside an open frame leaves it open
    send_event(ACT_START, 32'hAAAA_AAAA);
    send_event(ACT_UNUSED, 32'h5555_5555);
    send_event(ACT_END, 32'hAAAA_AAAA + 32'd16667);
    // clear closes the open frame, the end after it is ignored
    send_event(ACT_START, 32'h5555_5555);
    send_event(ACT_CLEAR, 32'hFFFF_FFFF);
    send_event(ACT_END, 32'h5555_5600);
    // zero duration at all-ones timestamps
    send_event(ACT_START, 32'hFFFF_FFFF);
    send_event(ACT_END, 32'hFFFF_FFFF);

    // random part: mostly start/end pairs, so the ring fills and overwrites,
    // with rare clears and some noise
    while (sent < RAND_ITEMS) begin
      if (sent % 100 < 2) tx_idle_on = ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        t0 = $urandom;
        send_event(ACT_START, t0);
        sent++;
        if ($urandom_range(0, 9) == 0) begin
          t0 = $urandom;
          send_event(ACT_START, t0);
          sent++;
        end
        send_event(ACT_END, t0 + pick_duration());
        sent++;
      end else if (sel < 82) begin
        send_event(ACT_CLEAR, $urandom);
        sent++;
      end else begin
        act = ACT_W'($urandom_range(0, 3));
        send_event(act, $urandom);
        if (act != ACT_UNUSED) sent++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give stray results a chance to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("frame_rate_averager: match");
    end else begin
      $display("frame_rate_averager: mismatch");
    end
    $finish;
  end

  // watchdog on cycles without any transfer
  initial begin
    wait (rst_n);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("frame_rate_averager: mismatch");
    $finish;
  end

endmodule
